@@ hdl/ttba_pkg.sv @@
// Package for the trade time bar aggregator.
// Field widths, item and store entry structs, controller command/status
// structs and saturating add helpers. No dependencies.
package ttba_pkg;

  localparam int INST_W   = 4;
  localparam int TIME_W   = 48;
  localparam int PRICE_W  = 24;
  localparam int QTY_W    = 24;
  localparam int PROD_W   = PRICE_W + QTY_W;
  localparam int TURN_W   = 64;
  localparam int SUM_W    = 40;
  localparam int CNT_W    = 16;
  localparam int AVG_W    = 24;
  localparam int WIN_W    = 16;
  localparam int NUM_CODES = 2 ** INST_W;

  localparam logic [WIN_W-1:0] WINDOW_MS_RESET = 16'd1000;

  typedef struct packed {
    logic [INST_W-1:0]  instrument;
    logic [TIME_W-1:0]  trade_time;
    logic [PRICE_W-1:0] trade_price;
    logic [QTY_W-1:0]   trade_qty;
    logic               trade_side;
  } trade_t;

  typedef struct packed {
    logic [INST_W-1:0] bar_instrument;
    logic [TIME_W-1:0] bar_time;
    logic [AVG_W-1:0]  bar_avg_price;
    logic [SUM_W-1:0]  bar_buy_qty;
    logic [SUM_W-1:0]  bar_sell_qty;
    logic [CNT_W-1:0]  bar_buy_count;
    logic [CNT_W-1:0]  bar_sell_count;
    logic              zero_qty_error;
  } bar_t;

  // one window per instrument slot
  typedef struct packed {
    logic [TIME_W-1:0] start;
    logic [TURN_W-1:0] turnover;
    logic [SUM_W-1:0]  qty_total;
    logic [SUM_W-1:0]  buy_qty;
    logic [SUM_W-1:0]  sell_qty;
    logic [CNT_W-1:0]  buy_cnt;
    logic [CNT_W-1:0]  sell_cnt;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic update;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic close;
    logic div_busy;
    logic out_free;
  } status_t;

  function automatic logic [TURN_W-1:0] sat_add_turn(logic [TURN_W-1:0] a,
                                                      logic [PROD_W-1:0] b);
    logic [TURN_W:0] s;
    s = {1'b0, a} + {{(TURN_W-PROD_W+1){1'b0}}, b};
    return s[TURN_W] ? {TURN_W{1'b1}} : s[TURN_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] sat_add_qty(logic [SUM_W-1:0] a,
                                                    logic [QTY_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {{(SUM_W-QTY_W+1){1'b0}}, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] a);
    return (a == {CNT_W{1'b1}}) ? a : a + CNT_W'(1);
  endfunction

endpackage

@@ hdl/ttba_trade_if.sv @@
// Trade channel interface: valid/ready handshake plus one trade item.
// Depends on ttba_pkg for field widths.
interface ttba_trade_if;
  logic                         valid;
  logic                         ready;
  logic [ttba_pkg::INST_W-1:0]  instrument;
  logic [ttba_pkg::TIME_W-1:0]  trade_time;
  logic [ttba_pkg::PRICE_W-1:0] trade_price;
  logic [ttba_pkg::QTY_W-1:0]   trade_qty;
  logic                         trade_side;

  modport source(output valid, instrument, trade_time, trade_price, trade_qty, trade_side,
                 input ready);
  modport sink(input valid, instrument, trade_time, trade_price, trade_qty, trade_side,
               output ready);
endinterface

@@ hdl/ttba_bar_if.sv @@
// Bar channel interface: valid/ready handshake plus one closed-bar item.
// Depends on ttba_pkg for field widths.
interface ttba_bar_if;
  logic                        valid;
  logic                        ready;
  logic [ttba_pkg::INST_W-1:0] bar_instrument;
  logic [ttba_pkg::TIME_W-1:0] bar_time;
  logic [ttba_pkg::AVG_W-1:0]  bar_avg_price;
  logic [ttba_pkg::SUM_W-1:0]  bar_buy_qty;
  logic [ttba_pkg::SUM_W-1:0]  bar_sell_qty;
  logic [ttba_pkg::CNT_W-1:0]  bar_buy_count;
  logic [ttba_pkg::CNT_W-1:0]  bar_sell_count;
  logic                        zero_qty_error;

  modport source(output valid, bar_instrument, bar_time, bar_avg_price, bar_buy_qty,
                 bar_sell_qty, bar_buy_count, bar_sell_count, zero_qty_error,
                 input ready);
  modport sink(input valid, bar_instrument, bar_time, bar_avg_price, bar_buy_qty,
               bar_sell_qty, bar_buy_count, bar_sell_count, zero_qty_error,
               output ready);
endinterface

@@ hdl/ttba_div.sv @@
// Restoring divider for the average price: 64-bit turnover over 40-bit
// quantity, 24-bit saturating quotient, one quotient bit per cycle. Uses ttba_pkg.
module ttba_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ttba_pkg::TURN_W-1:0]   num,
  input  logic [ttba_pkg::SUM_W-1:0]    den,
  output logic                          busy,
  output logic [ttba_pkg::AVG_W-1:0]    quo,
  output logic                          zero_err
);
  localparam int AW = ttba_pkg::AVG_W;
  localparam int SW = ttba_pkg::SUM_W;
  localparam int CW = $clog2(AW + 1);

  logic [CW-1:0] cnt_r;
  logic [SW-1:0] rem_r;
  logic [SW-1:0] den_r;
  logic [AW-1:0] lo_r;
  logic [AW-1:0] quo_r;
  logic          sat_r;
  logic          err_r;

  logic [SW:0]   trial;
  logic          ge;
  logic [SW-1:0] num_hi;

  assign num_hi = num[ttba_pkg::TURN_W-1:AW];
  assign trial  = {rem_r, lo_r[AW-1]};
  assign ge     = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      // quotient overflows 24 bits exactly when the high part reaches den
      if (den == '0 || num_hi >= den) begin
        cnt_r <= '0;
      end else begin
        cnt_r <= CW'(AW);
      end
    end else if (busy) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      err_r <= (den == '0);
      sat_r <= (den != '0) && (num_hi >= den);
      rem_r <= num_hi;
      den_r <= den;
      lo_r  <= num[AW-1:0];
      quo_r <= '0;
    end else if (busy) begin
      rem_r <= ge ? SW'(trial - {1'b0, den_r}) : trial[SW-1:0];
      lo_r  <= {lo_r[AW-2:0], 1'b0};
      quo_r <= {quo_r[AW-2:0], ge};
    end
  end

  assign busy     = (cnt_r != '0);
  assign quo      = sat_r ? {AW{1'b1}} : quo_r;
  assign zero_err = err_r;

endmodule

@@ hdl/ttba_datapath.sv @@
// Datapath: window store, per-trade update, bar capture, divider and the
// output register. Driven by ttba_ctrl commands. Uses ttba_pkg and ttba_div.
module ttba_datapath #(
  parameter int NUM_INSTRUMENTS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ttba_pkg::cmd_t              cmd,
  output ttba_pkg::status_t           status,
  input  ttba_pkg::trade_t            trade_in,
  input  logic                        cfg_we,
  input  logic [ttba_pkg::WIN_W-1:0]  cfg_wdata,
  input  logic                        out_ready,
  output logic                        out_valid,
  output ttba_pkg::bar_t              bar_out
);
  // only 16 codes reach the store, so deeper settings add no slots
  localparam int NUM_SLOTS = (NUM_INSTRUMENTS < ttba_pkg::NUM_CODES) ?
                             NUM_INSTRUMENTS : ttba_pkg::NUM_CODES;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int RANGE_W   = $clog2(NUM_INSTRUMENTS + 1) + ttba_pkg::INST_W;

  logic [ttba_pkg::WIN_W-1:0]  window_ms_r;
  ttba_pkg::trade_t            trade_r;
  logic [ttba_pkg::PROD_W-1:0] prod_r;
  logic [NUM_SLOTS-1:0]        open_r;
  ttba_pkg::entry_t            mem [NUM_SLOTS];
  ttba_pkg::entry_t            rd_data_r;
  ttba_pkg::entry_t            pend_r;
  logic [ttba_pkg::INST_W-1:0] pend_inst_r;
  logic                        out_valid_r;
  ttba_pkg::bar_t              out_bar_r;

  logic [SLOT_W-1:0]           slot;
  logic [SLOT_W-1:0]           rd_slot;
  logic                        in_range;
  logic                        was_open;
  logic [ttba_pkg::TIME_W:0]   diff;
  logic                        close_hit;
  ttba_pkg::entry_t            base;
  ttba_pkg::entry_t            upd;

  logic                        div_busy;
  logic [ttba_pkg::AVG_W-1:0]  div_quo;
  logic                        div_err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_ms_r <= ttba_pkg::WINDOW_MS_RESET;
    end else if (cfg_we) begin
      window_ms_r <= cfg_wdata;
    end
  end

  assign rd_slot = trade_in.instrument[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      trade_r   <= trade_in;
      prod_r    <= trade_in.trade_price * trade_in.trade_qty;
      rd_data_r <= mem[rd_slot];
    end
  end

  assign slot     = trade_r.instrument[SLOT_W-1:0];
  assign in_range = RANGE_W'(trade_r.instrument) < RANGE_W'(NUM_INSTRUMENTS);
  assign was_open = in_range && open_r[slot];
  assign diff     = {1'b0, trade_r.trade_time} - {1'b0, rd_data_r.start};
  // a trade before the opening time never closes the window
  assign close_hit = was_open && !diff[ttba_pkg::TIME_W] &&
                     (diff[ttba_pkg::TIME_W-1:0] >=
                      ttba_pkg::TIME_W'(window_ms_r));

  always_comb begin
    base = rd_data_r;
    if (close_hit || !was_open) begin
      base       = '0;
      base.start = trade_r.trade_time;
    end
    upd           = base;
    upd.turnover  = ttba_pkg::sat_add_turn(base.turnover, prod_r);
    upd.qty_total = ttba_pkg::sat_add_qty(base.qty_total, trade_r.trade_qty);
    if (trade_r.trade_side) begin
      upd.buy_qty = ttba_pkg::sat_add_qty(base.buy_qty, trade_r.trade_qty);
      upd.buy_cnt = ttba_pkg::sat_inc(base.buy_cnt);
    end else begin
      upd.sell_qty = ttba_pkg::sat_add_qty(base.sell_qty, trade_r.trade_qty);
      upd.sell_cnt = ttba_pkg::sat_inc(base.sell_cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && in_range) begin
      mem[slot] <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= '0;
    end else if (cmd.update && in_range) begin
      open_r[slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && close_hit) begin
      pend_r      <= rd_data_r;
      pend_inst_r <= trade_r.instrument;
    end
  end

  ttba_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.update && close_hit),
    .num      (rd_data_r.turnover),
    .den      (rd_data_r.qty_total),
    .busy     (div_busy),
    .quo      (div_quo),
    .zero_err (div_err)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_bar_r.bar_instrument <= pend_inst_r;
      out_bar_r.bar_time       <= pend_r.start;
      out_bar_r.bar_avg_price  <= div_quo;
      out_bar_r.bar_buy_qty    <= pend_r.buy_qty;
      out_bar_r.bar_sell_qty   <= pend_r.sell_qty;
      out_bar_r.bar_buy_count  <= pend_r.buy_cnt;
      out_bar_r.bar_sell_count <= pend_r.sell_cnt;
      out_bar_r.zero_qty_error <= div_err;
    end
  end

  assign status.close    = close_hit;
  assign status.div_busy = div_busy;
  assign status.out_free = !out_valid_r;
  assign out_valid       = out_valid_r;
  assign bar_out         = out_bar_r;

endmodule

@@ hdl/ttba_ctrl.sv @@
// Controller state machine: sequences accept, store update and bar emission.
// Talks to ttba_datapath through cmd_t / status_t from ttba_pkg.
module ttba_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output ttba_pkg::cmd_t    cmd,
  input  ttba_pkg::status_t status
);
  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_DIV
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        state_nxt = status.close ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        if (!status.div_busy && status.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready   = (state_r == S_IDLE);
  assign cmd.accept = in_ready && in_valid;
  assign cmd.update = (state_r == S_UPDATE);
  assign cmd.emit   = (state_r == S_DIV) && !status.div_busy && status.out_free;

endmodule

@@ hdl/trade_time_bar_aggregator_top.sv @@
// Trade time bar aggregator, top level.
// Channels: in_trade (sink) takes one trade item per valid/ready handshake;
// out_bar (source) gives one closed-bar item per handshake.
// cfg_we/cfg_wdata write the window length in ms (reset 1000); the user must
// write it only while idle, the block does not enforce it. Per instrument a window
// opens on its first trade and accumulates turnover, quantities and side counts;
// a trade at least window_ms after the opening time closes it, emits a bar (VWAP
// = turnover / quantity, truncated) and opens a new window holding that trade.
// Each trade is accepted with a store read, then updated and written back;
// a new trade is taken only after the write-back. A closing trade also runs
// the bit-serial divider: in_ready stays low until the divider is done and
// the output register is free, then the bar is loaded into it. A zero
// quantity sum or a saturated average skips the divider.
// The output register decouples the sides: trades keep being accepted while
// a bar waits; a second closing trade waits in the divider until the first
// bar is taken.
// Reset (rst_n low, synchronous) clears all windows and the output valid and
// sets the window length back to 1000.
module trade_time_bar_aggregator_top #(
  parameter int NUM_INSTRUMENTS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  ttba_trade_if.sink                 in_trade,
  ttba_bar_if.source                 out_bar,
  input  logic                       cfg_we,
  input  logic [ttba_pkg::WIN_W-1:0] cfg_wdata
);
  ttba_pkg::cmd_t    cmd;
  ttba_pkg::status_t status;
  ttba_pkg::trade_t  trade;
  ttba_pkg::bar_t    bar;
  logic              in_ready;
  logic              out_valid;

  assign trade.instrument  = in_trade.instrument;
  assign trade.trade_time  = in_trade.trade_time;
  assign trade.trade_price = in_trade.trade_price;
  assign trade.trade_qty   = in_trade.trade_qty;
  assign trade.trade_side  = in_trade.trade_side;
  assign in_trade.ready    = in_ready;

  ttba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_trade.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  ttba_datapath #(
    .NUM_INSTRUMENTS (NUM_INSTRUMENTS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .trade_in  (trade),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_ready (out_bar.ready),
    .out_valid (out_valid),
    .bar_out   (bar)
  );

  assign out_bar.valid          = out_valid;
  assign out_bar.bar_instrument = bar.bar_instrument;
  assign out_bar.bar_time       = bar.bar_time;
  assign out_bar.bar_avg_price  = bar.bar_avg_price;
  assign out_bar.bar_buy_qty    = bar.bar_buy_qty;
  assign out_bar.bar_sell_qty   = bar.bar_sell_qty;
  assign out_bar.bar_buy_count  = bar.bar_buy_count;
  assign out_bar.bar_sell_count = bar.bar_sell_count;
  assign out_bar.zero_qty_error = bar.zero_qty_error;

endmodule
